// File: rtl/prd_pkg.sv
package prd_pkg;

    localparam int VALUE_W    = 32;
    localparam int SUM_W      = 64;
    localparam int NORM_AW    = 8;
    localparam int NORM_DEPTH = 1 << NORM_AW;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_TABLE = 2'd1;
    localparam logic [1:0] FUNC_TERM  = 2'd2;

    localparam logic [1:0] ST_POSITION  = 2'd0;
    localparam logic [1:0] ST_FINAL     = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         data_byte;
        logic [NORM_AW-1:0] table_index;
        logic [VALUE_W-1:0] table_value;
        logic [VALUE_W-1:0] start_doc;
    } req_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] doc_number;
        logic [VALUE_W-1:0] frequency;
        logic [VALUE_W-1:0] position;
        logic [VALUE_W-1:0] boost;
        logic [VALUE_W-1:0] impact;
        logic [1:0]         status;
        logic               last;
    } rsp_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/prd_ram.sv
module prd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/prd_div.sv
module prd_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [prd_pkg::SUM_W-1:0]             dividend,
    input  logic [prd_pkg::VALUE_W-1:0]           divisor,
    output logic [prd_pkg::VALUE_W-1:0]           quotient,
    output prd_pkg::div_status_t                  status
);

    localparam int W   = prd_pkg::VALUE_W;
    localparam int CW  = $clog2(W);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b0;
            done_next = 1'b1;
            if (divisor == '0)
            begin
                quo_next = '0;
            end
            else if (dividend[2*W-1:W] >= divisor)
            begin
                // quotient would not fit: saturate
                quo_next = '1;
            end
            else
            begin
                rem_next  = dividend[2*W-1:W];
                quo_next  = dividend[W-1:0];
                busy_next = 1'b1;
                done_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/posting_record_decoder_core.sv
// Channel | Signals                     | Beat
// --------+-----------------------------+-------------------------------------
// req     | req_valid, req_ready, req   | one stream byte, table load or term
// rsp     | rsp_valid, rsp_ready, rsp   | one position, empty or malformed
//
// Integer bytes, table loads and term starts are handled in the idle state as they are taken.
// A boost byte passes through the beat, the norm table read and the boost sum update.
// The final position of a record then waits for the 32-step
// restoring divider that forms the average boost.
// Reset clears all parser state; the norm table holds garbage until loaded.
// A held result blocks only beats that would produce a result themselves.
module posting_record_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  prd_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output prd_pkg::rsp_item_t  rsp
);

    localparam int W = prd_pkg::VALUE_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BOOST = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    localparam logic [1:0] PH_DOC   = 2'd0;
    localparam logic [1:0] PH_FREQ  = 2'd1;
    localparam logic [1:0] PH_POS   = 2'd2;
    localparam logic [1:0] PH_BOOST = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [W-1:0]                doc_reg, doc_next;
    logic [W-1:0]                pos_sum_reg, pos_sum_next;
    logic [W-1:0]                acc_reg, acc_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [W-1:0]                pleft_reg, pleft_next;
    logic [W-1:0]                freq_reg, freq_next;
    logic [prd_pkg::SUM_W-1:0]   bsum_reg, bsum_next;
    logic                        out_valid_reg, out_valid_next;
    prd_pkg::rsp_item_t          out_reg, out_next;

    logic                        req_fire;
    logic                        slot_free;
    logic                        imm_emit;
    logic [5:0]                  shamt;
    logic [W-1:0]                acc_or;
    logic [prd_pkg::SUM_W-1:0]   bsum_add;

    logic                        ram_we;
    logic                        ram_re;
    logic [W-1:0]                ram_rdata;
    logic                        div_start;
    logic [W-1:0]                div_quo;
    prd_pkg::div_status_t        div_st;

    assign shamt    = {cnt_reg, 3'b000} - {3'b000, cnt_reg};
    assign acc_or   = acc_reg | (W'(req.data_byte[6:0]) << shamt);
    assign bsum_add = bsum_reg + prd_pkg::SUM_W'(ram_rdata);

    assign slot_free = !out_valid_reg || rsp_ready;
    assign imm_emit  = (req.func == prd_pkg::FUNC_BYTE) && (phase_reg != PH_BOOST)
                     && ((req.data_byte[7] && (cnt_reg >= 3'd4))
                     || (!req.data_byte[7] && (phase_reg == PH_FREQ)
                         && (acc_or == '0)));
    assign req_ready = (state_reg == S_IDLE) && (slot_free || !imm_emit);
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        doc_next       = doc_reg;
        pos_sum_next   = pos_sum_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        pleft_next     = pleft_reg;
        freq_next      = freq_reg;
        bsum_next      = bsum_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.func)
                        prd_pkg::FUNC_BYTE:
                        begin
                            if (phase_reg == PH_BOOST)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_BOOST;
                            end
                            else if (req.data_byte[7])
                            begin
                                if (cnt_reg >= 3'd4)
                                begin
                                    out_valid_next      = 1'b1;
                                    out_next            = '0;
                                    out_next.doc_number = doc_reg;
                                    out_next.status     = prd_pkg::ST_MALFORMED;
                                    out_next.last       = 1'b1;
                                    phase_next   = PH_DOC;
                                    acc_next     = '0;
                                    cnt_next     = '0;
                                    pos_sum_next = '0;
                                    bsum_next    = '0;
                                    pleft_next   = '0;
                                end
                                else
                                begin
                                    acc_next = acc_or;
                                    cnt_next = cnt_reg + 3'd1;
                                end
                            end
                            else
                            begin
                                acc_next = '0;
                                cnt_next = '0;
                                case (phase_reg)
                                    PH_DOC:
                                    begin
                                        doc_next     = doc_reg + {1'b0, acc_or[W-1:1]};
                                        pos_sum_next = '0;
                                        bsum_next    = '0;
                                        if (acc_or[0])
                                        begin
                                            freq_next  = W'(1);
                                            pleft_next = W'(1);
                                            phase_next = PH_POS;
                                        end
                                        else
                                        begin
                                            phase_next = PH_FREQ;
                                        end
                                    end
                                    PH_FREQ:
                                    begin
                                        freq_next = acc_or;
                                        if (acc_or == '0)
                                        begin
                                            out_valid_next      = 1'b1;
                                            out_next            = '0;
                                            out_next.doc_number = doc_reg;
                                            out_next.status     = prd_pkg::ST_EMPTY;
                                            out_next.last       = 1'b1;
                                            phase_next   = PH_DOC;
                                            pos_sum_next = '0;
                                            bsum_next    = '0;
                                            pleft_next   = '0;
                                        end
                                        else
                                        begin
                                            pleft_next = acc_or;
                                            phase_next = PH_POS;
                                        end
                                    end
                                    default:
                                    begin
                                        pos_sum_next = pos_sum_reg + acc_or;
                                        phase_next   = PH_BOOST;
                                    end
                                endcase
                            end
                        end
                        prd_pkg::FUNC_TABLE:
                        begin
                            ram_we = 1'b1;
                        end
                        prd_pkg::FUNC_TERM:
                        begin
                            doc_next     = req.start_doc;
                            phase_next   = PH_DOC;
                            acc_next     = '0;
                            cnt_next     = '0;
                            pos_sum_next = '0;
                            bsum_next    = '0;
                            pleft_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BOOST:
            begin
                bsum_next  = bsum_add;
                pleft_next = pleft_reg - W'(1);
                phase_next = PH_POS;
                if (pleft_reg == W'(1))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.doc_number = doc_reg;
                    out_next.frequency  = freq_reg;
                    out_next.position   = pos_sum_reg;
                    out_next.boost      = ram_rdata;
                    out_next.impact     = '0;
                    out_next.status     = prd_pkg::ST_POSITION;
                    out_next.last       = 1'b0;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                // hold until the average is ready and the output slot drains
                if (div_st.done && slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.doc_number = doc_reg;
                    out_next.frequency  = freq_reg;
                    out_next.position   = pos_sum_reg;
                    out_next.boost      = ram_rdata;
                    out_next.impact     = div_quo;
                    out_next.status     = prd_pkg::ST_FINAL;
                    out_next.last       = 1'b1;
                    phase_next   = PH_DOC;
                    acc_next     = '0;
                    cnt_next     = '0;
                    pos_sum_next = '0;
                    bsum_next    = '0;
                    pleft_next   = '0;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_DOC;
            doc_reg       <= '0;
            pos_sum_reg   <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            pleft_reg     <= '0;
            freq_reg      <= '0;
            bsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            doc_reg       <= doc_next;
            pos_sum_reg   <= pos_sum_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            pleft_reg     <= pleft_next;
            freq_reg      <= freq_next;
            bsum_reg      <= bsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    prd_ram #(
        .WIDTH (prd_pkg::VALUE_W),
        .DEPTH (prd_pkg::NORM_DEPTH)
    ) u_norm_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req.table_index),
        .wdata (req.table_value),
        .re    (ram_re),
        .raddr (req.data_byte),
        .rdata (ram_rdata)
    );

    prd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (bsum_add),
        .divisor  (freq_reg),
        .quotient (div_quo),
        .status   (div_st)
    );

`ifndef SYNTHESIS
    a_boost_has_positions: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BOOST) |-> (pleft_reg != '0))
        else $error("boost phase with no positions left");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

    a_no_ram_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (!ram_re && !ram_we && !req_ready))
        else $error("table access or beat taken outside idle");

    a_impact_final_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != prd_pkg::ST_FINAL)) |-> (rsp.impact == '0))
        else $error("impact set on a non-final result");
`endif

endmodule

// File: dv/posting_record_decoder_core_tb.sv
`timescale 1ns / 100ps

module posting_record_decoder_core_tb;

    import prd_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         RANDOM_BEATS = 1400;
    localparam int         TAIL_CYCLES  = 60;

    typedef enum logic [1:0] {PH_DOC_CODE, PH_FREQ, PH_DELTA, PH_BOOST} parse_phase_e;

    typedef struct {
        req_item_t beat;
        bit        typed;
        rsp_item_t result;
    } directed_row_t;

    localparam rsp_item_t NO_RESULT = '0;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    // shadow of the decoder state
    logic [31:0]  doc_base      = '0;
    logic [31:0]  pos_sum       = '0;
    logic [31:0]  varint_acc    = '0;
    logic [2:0]   varint_len    = '0;
    logic [31:0]  positions_due = '0;
    logic [31:0]  record_freq   = '0;
    logic [63:0]  boost_total   = '0;
    parse_phase_e parse_at      = PH_DOC_CODE;
    logic [31:0]  norm_shadow [256];
    bit           norm_loaded [256];
    int           loaded_list [$];

    rsp_item_t     expected_postings [$];
    directed_row_t directed_rows [$];
    int            mismatch_count = 0;
    int            beats_sent     = 0;
    bit            sender_calm    = 1'b0;
    bit            receiver_calm  = 1'b0;

    posting_record_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void drop_record();
        parse_at      = PH_DOC_CODE;
        varint_acc    = '0;
        varint_len    = '0;
        pos_sum       = '0;
        boost_total   = '0;
        positions_due = '0;
    endfunction

    function automatic bit decode_posting_beat(input req_item_t beat, output rsp_item_t result);
        logic [31:0] value;
        logic [31:0] boost;
        logic [63:0] average;
        result = NO_RESULT;
        case (beat.func)
            FUNC_TABLE:
            begin
                norm_shadow[beat.table_index] = beat.table_value;
                if (!norm_loaded[beat.table_index])
                begin
                    norm_loaded[beat.table_index] = 1'b1;
                    loaded_list.push_back(int'(beat.table_index));
                end
                return 1'b0;
            end
            FUNC_TERM:
            begin
                doc_base = beat.start_doc;
                drop_record();
                return 1'b0;
            end
            FUNC_BYTE: ;
            default: return 1'b0;
        endcase

        if (parse_at == PH_BOOST)
        begin
            boost         = norm_shadow[beat.data_byte];
            boost_total   = boost_total + {32'b0, boost};
            positions_due = positions_due - 1;
            parse_at      = PH_DELTA;
            result.doc_number = doc_base;
            result.frequency  = record_freq;
            result.position   = pos_sum;
            result.boost      = boost;
            if (positions_due == 0)
            begin
                average = (record_freq != 0) ? boost_total / {32'b0, record_freq} : 64'd0;
                if (average > 64'hFFFF_FFFF)
                    average = 64'hFFFF_FFFF;
                result.impact = average[31:0];
                result.status = ST_FINAL;
                result.last   = 1'b1;
                drop_record();
            end
            else
            begin
                result.status = ST_POSITION;
                result.last   = 1'b0;
            end
            return 1'b1;
        end

        // payload above bit 31 of a fifth byte falls off here
        varint_acc = varint_acc | (32'(beat.data_byte[6:0]) << (7 * varint_len));
        if (beat.data_byte[7])
        begin
            if (varint_len >= 3'd4)
            begin
                result.doc_number = doc_base;
                result.status     = ST_MALFORMED;
                result.last       = 1'b1;
                drop_record();
                return 1'b1;
            end
            varint_len = varint_len + 1'b1;
            return 1'b0;
        end

        value      = varint_acc;
        varint_acc = '0;
        varint_len = '0;
        case (parse_at)
            PH_DOC_CODE:
            begin
                doc_base    = doc_base + (value >> 1);
                pos_sum     = '0;
                boost_total = '0;
                if (value[0])
                begin
                    record_freq   = 32'd1;
                    positions_due = 32'd1;
                    parse_at      = PH_DELTA;
                end
                else
                    parse_at = PH_FREQ;
            end
            PH_FREQ:
            begin
                record_freq = value;
                if (value == 0)
                begin
                    result.doc_number = doc_base;
                    result.status     = ST_EMPTY;
                    result.last       = 1'b1;
                    drop_record();
                    return 1'b1;
                end
                positions_due = value;
                parse_at      = PH_DELTA;
            end
            default:
            begin
                pos_sum  = pos_sum + value;
                parse_at = PH_BOOST;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic note_mismatch(input string what, input rsp_item_t want, input rsp_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected doc %h freq %h pos %h boost %h impact %h status %0d last %0d",
                     want.doc_number, want.frequency, want.position, want.boost,
                     want.impact, want.status, want.last);
            $display("  actual   doc %h freq %h pos %h boost %h impact %h status %0d last %0d",
                     got.doc_number, got.frequency, got.position, got.boost,
                     got.impact, got.status, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_postings.size() == 0)
                note_mismatch("result with nothing expected", NO_RESULT, rsp);
            else
            begin
                want = expected_postings.pop_front();
                if (rsp !== want)
                    note_mismatch("result mismatch", want, rsp);
            end
        end
    end

    // Hold each beat until accepted, then advance the shadow state.
    task automatic send_beat(input req_item_t item, input bit typed, input rsp_item_t typed_result);
        int        gap;
        rsp_item_t predicted;
        if ($urandom_range(0, 63) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        // never point a boost byte at an unloaded table entry
        if (item.func == FUNC_BYTE && parse_at == PH_BOOST && !norm_loaded[item.data_byte])
            item.data_byte = 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        if (decode_posting_beat(item, predicted))
            expected_postings.push_back(typed ? typed_result : predicted);
        else if (typed)
            expected_postings.push_back(typed_result);
        if (item.func != FUNC_UNUSED)
            beats_sent++;
    endtask

    function automatic req_item_t random_beat(input logic [1:0] func);
        logic [95:0] noise;
        req_item_t   item;
        noise     = {$urandom(), $urandom(), $urandom()};
        item      = noise[$bits(req_item_t)-1:0];
        item.func = func;
        return item;
    endfunction

    task automatic send_byte(input logic [7:0] data);
        req_item_t item;
        item           = random_beat(FUNC_BYTE);
        item.data_byte = data;
        send_beat(item, 1'b0, NO_RESULT);
    endtask

    task automatic send_varint(input logic [31:0] value);
        int         len;
        int         k;
        logic [7:0] data;
        len = 1;
        while (len < 5 && (value >> (7 * len)) != 0)
            len++;
        // now and then pad with empty high groups
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(len, 5);
        for (k = 0; k < len; k++)
        begin
            data    = 8'(value >> (7 * k));
            data[7] = (k < len - 1);
            if (k == 4)
                data[6:4] = 3'($urandom_range(0, 7));
            send_byte(data);
        end
    endtask

    task automatic break_record(input bit by_term);
        int k;
        if (by_term)
            send_beat(random_beat(FUNC_TERM), 1'b0, NO_RESULT);
        else
            for (k = 0; k < 5; k++)
                send_byte(8'h80 | 8'($urandom_range(0, 127)));
    endtask

    // One record; cut selects the integer at which it gets broken off.
    task automatic send_record(input int cut, input bit by_term);
        logic [31:0] freq;
        logic [31:0] code;
        int          k;
        if (cut < 4)
            freq = $urandom() >> $urandom_range(0, 31);
        else if ($urandom_range(0, 15) == 0)
            freq = 32'd0;
        else if ($urandom_range(0, 39) == 0)
            freq = $urandom_range(5, 12);
        else
            freq = $urandom_range(1, 4);
        code    = $urandom() >> $urandom_range(0, 31);
        code[0] = (freq == 1) && ($urandom_range(0, 1) == 1);

        if (cut == 0)
        begin
            break_record(by_term);
            return;
        end
        send_varint(code);
        if (!code[0])
        begin
            if (cut == 1)
            begin
                break_record(by_term);
                return;
            end
            send_varint(freq);
        end
        for (k = 0; k < freq; k++)
        begin
            if (cut == k + 2)
            begin
                break_record(by_term);
                return;
            end
            send_varint($urandom() >> $urandom_range(0, 31));
            send_byte(8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]));
        end
    endtask

    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                receiver_calm = !receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, 6);
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    initial
    begin
        #5_000_000;
        $display("posting_record_decoder_core test failed");
        $finish;
    end

    initial
    begin
        int pick;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;

        // table loads: max boost, 1.5
        directed_rows.push_back('{'{FUNC_TABLE, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_TABLE, 8'h00, 8'hFF, 32'h0001_8000, 32'h0}, 1'b0, NO_RESULT});
        // odd doc code, one position at max boost
        directed_rows.push_back('{'{FUNC_BYTE, 8'h03, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h05, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h00, 8'h00, 32'h0, 32'h0}, 1'b1,
            '{32'd1, 32'd1, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_FINAL, 1'b1}});
        // even doc code with zero frequency
        directed_rows.push_back('{'{FUNC_BYTE, 8'h02, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h00, 8'h00, 32'h0, 32'h0}, 1'b1,
            '{32'd2, 32'd0, 32'd0, 32'd0, 32'd0, ST_EMPTY, 1'b1}});
        // new term at the top, then a max doc code so the document number wraps
        directed_rows.push_back('{'{FUNC_TERM, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFFF}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'hFF, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'hFF, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'hFF, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'hFF, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h0F, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        // five byte delta whose top payload bits drop off
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h7F, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'hFF, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        // unused function code must be ignored
        directed_rows.push_back('{'{FUNC_UNUSED, 8'h85, 8'h12, 32'hDEAD_BEEF, 32'h1234_5678},
            1'b0, NO_RESULT});
        // too long an integer
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b0, NO_RESULT});
        directed_rows.push_back('{'{FUNC_BYTE, 8'h80, 8'h00, 32'h0, 32'h0}, 1'b1,
            '{32'h7FFF_FFFE, 32'd0, 32'd0, 32'd0, 32'd0, ST_MALFORMED, 1'b1}});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].result);

        while (beats_sent < RANDOM_BEATS + directed_rows.size())
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                send_record(1000, 1'b0);
            else if (pick < 84)
                send_record($urandom_range(0, 3), 1'($urandom_range(0, 1)));
            else if (pick < 90)
                send_beat(random_beat(FUNC_TABLE), 1'b0, NO_RESULT);
            else if (pick < 93)
                send_beat(random_beat(FUNC_TERM), 1'b0, NO_RESULT);
            else if (pick < 97)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_beat(random_beat(FUNC_UNUSED), 1'b0, NO_RESULT);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_postings.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("posting_record_decoder_core test passed");
        else
            $display("posting_record_decoder_core test failed");
        $finish;
    end

endmodule
